@@ rtl/core/rdse_pkg.sv @@
// ----------------------------------------------------------------------------
// rdse_pkg
// Types, constants and the field-offset function for the radiotap dBm signal
// extractor.
// ----------------------------------------------------------------------------
package rdse_pkg;

  localparam int unsigned FIELD_COUNT = 6;
  localparam int unsigned SIGNAL_BIT  = 5;
  localparam int unsigned EXT_BIT     = 31;

  localparam logic [15:0] HDR_MIN_LEN    = 16'd8;
  localparam logic [15:0] BYTE_COUNT_MAX = 16'hFFFF;

  // byte positions of the fixed radiotap header words
  localparam logic [15:0] IDX_LEN_LO      = 16'd2;
  localparam logic [15:0] IDX_LEN_HI      = 16'd3;
  localparam logic [15:0] IDX_FLAGS_FIRST = 16'd4;
  localparam logic [15:0] IDX_FLAGS_LAST  = 16'd7;

  // alignment and size of present fields 0..5
  localparam logic [5:0] FIELD_ALIGN [FIELD_COUNT] = '{6'd8, 6'd1, 6'd1, 6'd2, 6'd1, 6'd1};
  localparam logic [5:0] FIELD_SIZE  [FIELD_COUNT] = '{6'd8, 6'd1, 6'd1, 6'd4, 6'd2, 6'd1};

  typedef enum logic [2:0] {
    STATUS_FOUND   = 3'd0,
    STATUS_SHORT   = 3'd1,
    STATUS_BAD_LEN = 3'd2,
    STATUS_EXT     = 3'd3,
    STATUS_ABSENT  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    status_e           status;
    logic signed [7:0] rssi;
  } result_t;

  // Offset of the dBm signal field, given present bits 0..4 (max 24).
  function automatic logic [5:0] signal_offset(input logic [SIGNAL_BIT-1:0] flags);
    logic [5:0] pos;
    pos = HDR_MIN_LEN[5:0];
    for (int b = 0; b < SIGNAL_BIT; b++) begin
      if (flags[b]) begin
        pos = (pos + (FIELD_ALIGN[b] - 6'd1)) & ~(FIELD_ALIGN[b] - 6'd1);
        pos = pos + FIELD_SIZE[b];
      end
    end
    return pos;
  endfunction

endpackage

@@ rtl/core/rdse_in_reg.sv @@
// ----------------------------------------------------------------------------
// rdse_in_reg
// Input register: holds one byte item until the parser takes it.
// ----------------------------------------------------------------------------
module rdse_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic               res_free,
  output logic               take,
  output rdse_pkg::byte_item_t item
);
  import rdse_pkg::*;

  logic item_valid;

  // a last byte needs room in the result register; others pass freely
  assign take     = item_valid && (!item.last || res_free);
  assign in_stall = item_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.data <= data_byte;
      item.last <= last_byte;
    end
  end

endmodule

@@ rtl/core/rdse_parse.sv @@
// ----------------------------------------------------------------------------
// rdse_parse
// Header state registers and per-byte capture; evaluates the packet on its
// last byte.
// ----------------------------------------------------------------------------
module rdse_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  rdse_pkg::byte_item_t item,
  output logic                 res_load,
  output rdse_pkg::result_t    res
);
  import rdse_pkg::*;

  logic [15:0] byte_count, byte_count_next;
  logic [15:0] header_length, header_length_next;
  logic [31:0] present_flags, present_flags_next;
  logic [7:0]  signal_byte, signal_byte_next;
  logic [5:0]  sig_off;
  logic [5:0]  sig_end;

  always_comb begin
    header_length_next = header_length;
    present_flags_next = present_flags;
    signal_byte_next   = signal_byte;
    sig_off            = signal_offset(present_flags[SIGNAL_BIT-1:0]);

    if (byte_count == IDX_LEN_LO) begin
      header_length_next[7:0] = item.data;
    end else if (byte_count == IDX_LEN_HI) begin
      header_length_next[15:8] = item.data;
    end else if (byte_count >= IDX_FLAGS_FIRST && byte_count <= IDX_FLAGS_LAST) begin
      present_flags_next[{byte_count[1:0], 3'b000} +: 8] = item.data;
    end else if (byte_count >= HDR_MIN_LEN && present_flags[SIGNAL_BIT]
                 && byte_count == {10'd0, sig_off}) begin
      signal_byte_next = item.data;
    end

    byte_count_next = (byte_count != BYTE_COUNT_MAX) ? byte_count + 16'd1 : byte_count;
  end

  // fields are laid out in order, so only the end of the signal field matters
  assign sig_end = signal_offset(present_flags_next[SIGNAL_BIT-1:0]) + 6'd1;

  always_comb begin
    res.rssi = 8'sd0;
    if (byte_count_next < HDR_MIN_LEN) begin
      res.status = STATUS_SHORT;
    end else if (header_length_next > byte_count_next || header_length_next < HDR_MIN_LEN) begin
      res.status = STATUS_BAD_LEN;
    end else if (present_flags_next[EXT_BIT]) begin
      res.status = STATUS_EXT;
    end else if (present_flags_next[SIGNAL_BIT] && {10'd0, sig_end} <= header_length_next) begin
      res.status = STATUS_FOUND;
      res.rssi   = signal_byte_next;
    end else begin
      res.status = STATUS_ABSENT;
    end
  end

  assign res_load = take && item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      header_length <= '0;
      present_flags <= '0;
      signal_byte   <= '0;
    end else if (take) begin
      if (item.last) begin
        byte_count    <= '0;
        header_length <= '0;
        present_flags <= '0;
        signal_byte   <= '0;
      end else begin
        byte_count    <= byte_count_next;
        header_length <= header_length_next;
        present_flags <= present_flags_next;
        signal_byte   <= signal_byte_next;
      end
    end
  end

endmodule

@@ rtl/core/rdse_out_reg.sv @@
// ----------------------------------------------------------------------------
// rdse_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module rdse_out_reg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     res_load,
  input  rdse_pkg::result_t        res,
  output logic                     res_free,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               status,
  output logic signed [7:0]        rssi_dbm
);
  import rdse_pkg::*;

  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status   <= res.status;
      rssi_dbm <= res.rssi;
    end
  end

endmodule

@@ rtl/core/radiotap_dbm_signal_extractor_unit.sv @@
// ----------------------------------------------------------------------------
// radiotap_dbm_signal_extractor_unit
// Top level: extracts the dBm antenna signal from a radiotap header.
// ----------------------------------------------------------------------------
// Packet bytes enter one item per cycle while in_stall is low, the final byte
// flagged by last_byte. The length word, present word and signal byte are
// captured on the fly, and a single result item (status, rssi_dbm) follows
// each final byte once it has passed the input register and then the result
// register. Bytes other than the final one are always taken at one per cycle;
// a final byte waits only while a previous result is held by out_stall.
// rssi_dbm reads zero whenever status is not found.
module radiotap_dbm_signal_extractor_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic signed [7:0] rssi_dbm
);
  import rdse_pkg::*;

  byte_item_t item;
  result_t    res;
  logic       take;
  logic       res_free;
  logic       res_load;

  rdse_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .res_free  (res_free),
    .take      (take),
    .item      (item)
  );

  rdse_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .res_load (res_load),
    .res      (res)
  );

  rdse_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .rssi_dbm  (rssi_dbm)
  );

endmodule

@@ rtl/core/rdse_checker.sv @@
// ----------------------------------------------------------------------------
// rdse_checker
// Port-level assertions for the radiotap dBm signal extractor.
// ----------------------------------------------------------------------------
module rdse_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [7:0]        data_byte,
  input logic              last_byte,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        status,
  input logic signed [7:0] rssi_dbm
);
  import rdse_pkg::*;

  // held result item must not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(rssi_dbm))
    else $error("result item changed while stalled");

  a_rssi_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_FOUND |-> rssi_dbm == 8'sd0)
    else $error("rssi nonzero on failed packet");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= STATUS_ABSENT)
    else $error("status code out of range");

  // input only backs up behind a held result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind radiotap_dbm_signal_extractor_unit rdse_checker u_rdse_checker (.*);

@@ sim/radiotap_dbm_signal_extractor_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radiotap_dbm_signal_extractor_checker
// Watches both channels of the dBm signal extractor. It tracks the radiotap
// header of each packet byte by byte, forms the expected status and rssi at
// the final byte, and compares each result item against the oldest one due.
// ----------------------------------------------------------------------------
module radiotap_dbm_signal_extractor_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        status,
  input  logic signed [7:0] rssi_dbm,
  output int                errors,
  output int                pending
);
  import rdse_pkg::*;

  typedef struct {
    status_e           status;
    logic signed [7:0] rssi;
  } rssi_report_t;

  // alignment and size of present fields 0..5 (tsft, flags, rate, channel,
  // fhss, dbm signal)
  localparam int unsigned FLD_ALIGN [6] = '{8, 1, 1, 2, 1, 1};
  localparam int unsigned FLD_SIZE  [6] = '{8, 1, 1, 4, 2, 1};
  localparam int unsigned DBM_BIT       = 5;
  localparam int unsigned EXT_FLAG_BIT  = 31;
  localparam int unsigned MIN_HDR       = 8;

  rssi_report_t reports_due[$];

  logic [15:0] seen_bytes;
  logic [15:0] rt_length;
  logic [31:0] rt_present;
  logic [7:0]  dbm_capture;

  // Aligned offset of the dBm field; fits drops if any present field among
  // bits 0..5 runs past limit.
  function automatic int unsigned dbm_field_offset(input logic [31:0] flags,
                                                   input int unsigned limit,
                                                   output bit fits);
    int unsigned pos;
    bit          done;
    pos  = MIN_HDR;
    done = 1'b0;
    fits = 1'b1;
    for (int b = 0; b < 6; b++) begin
      if (!done && flags[b]) begin
        if (FLD_ALIGN[b] > 1)
          pos = (pos + FLD_ALIGN[b] - 1) & ~(FLD_ALIGN[b] - 1);
        if (pos + FLD_SIZE[b] > limit)
          fits = 1'b0;
        if (b == DBM_BIT)
          done = 1'b1;
        else
          pos = pos + FLD_SIZE[b];
      end
    end
    return pos;
  endfunction

  task automatic clear_packet();
    seen_bytes  = '0;
    rt_length   = '0;
    rt_present  = '0;
    dbm_capture = '0;
  endtask

  task automatic track_byte(input logic [7:0] d, input logic l);
    int unsigned  idx;
    int unsigned  sig_pos;
    bit           fits;
    rssi_report_t rep;
    idx = seen_bytes;
    if (idx == 2)
      rt_length[7:0] = d;
    else if (idx == 3)
      rt_length[15:8] = d;
    else if (idx >= 4 && idx <= 7)
      rt_present = rt_present | ({24'd0, d} << ((idx - 4) * 8));
    else if (idx >= MIN_HDR && rt_present[DBM_BIT]) begin
      sig_pos = dbm_field_offset(rt_present, 32'hFFFF_FFFF, fits);
      if (sig_pos == idx)
        dbm_capture = d;
    end

    if (seen_bytes != 16'hFFFF)
      seen_bytes = seen_bytes + 16'd1;

    if (l) begin
      rep.rssi = '0;
      if (seen_bytes < MIN_HDR)
        rep.status = STATUS_SHORT;
      else if (rt_length > seen_bytes || rt_length < MIN_HDR)
        rep.status = STATUS_BAD_LEN;
      else if (rt_present[EXT_FLAG_BIT])
        rep.status = STATUS_EXT;
      else begin
        sig_pos = dbm_field_offset(rt_present, rt_length, fits);
        if (fits && rt_present[DBM_BIT]) begin
          rep.status = STATUS_FOUND;
          rep.rssi   = dbm_capture;
        end else
          rep.status = STATUS_ABSENT;
      end
      reports_due.push_back(rep);
      clear_packet();
    end
  endtask

  task automatic check_report(input logic [2:0] st, input logic signed [7:0] rs);
    rssi_report_t rep;
    if (reports_due.size() == 0) begin
      $display("%0t: unexpected result item: status %0d rssi %0d", $time, st, rs);
      errors = errors + 1;
    end else begin
      rep = reports_due.pop_front();
      if (st !== rep.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, rep.status, st);
        errors = errors + 1;
      end
      if (rs !== rep.rssi) begin
        $display("%0t: rssi_dbm mismatch: expected %0d actual %0d",
                 $time, rep.rssi, rs);
        errors = errors + 1;
      end
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    clear_packet();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_packet();
    end else begin
      if (out_valid && !out_stall)
        check_report(status, rssi_dbm);
      if (in_valid && !in_stall)
        track_byte(data_byte, last_byte);
    end
    pending = reports_due.size();
  end

endmodule

@@ sim/radiotap_dbm_signal_extractor_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radiotap_dbm_signal_extractor_unit_tb
// Feeds packets to the dBm signal extractor: a directed set covering every
// status and the field extremes, then random packets, mostly well-formed
// headers with random present bits and lengths. Both channels idle at
// random; the checker predicts and compares.
// ----------------------------------------------------------------------------
module radiotap_dbm_signal_extractor_unit_tb;

  localparam int RANDOM_BYTES = 1430;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        data_byte;
  logic              last_byte;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        status;
  logic signed [7:0] rssi_dbm;

  int errors;
  int pending;
  int cycle_cnt;

  logic [7:0] pkt_q[$];

  radiotap_dbm_signal_extractor_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .rssi_dbm  (rssi_dbm)
  );

  radiotap_dbm_signal_extractor_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .rssi_dbm  (rssi_dbm),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  // header bytes are placed over the fill; fill is random when rand_fill
  task automatic build_packet(input int unsigned plen, input logic [15:0] hlen,
                              input logic [31:0] pres, input bit rand_fill,
                              input logic [7:0] fill);
    logic [7:0] b;
    pkt_q.delete();
    for (int unsigned i = 0; i < plen; i++) begin
      b = rand_fill ? 8'($urandom) : fill;
      case (i)
        2: b = hlen[7:0];
        3: b = hlen[15:8];
        4: b = pres[7:0];
        5: b = pres[15:8];
        6: b = pres[23:16];
        7: b = pres[31:24];
        default: ;
      endcase
      pkt_q.push_back(b);
    end
  endtask

  task automatic send_packet(input bit no_gaps);
    int gap;
    bit quiet;
    quiet = no_gaps || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < pkt_q.size(); i++) begin
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid  <= 1'b1;
      data_byte <= pkt_q[i];
      last_byte <= (i == pkt_q.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
  endtask

  task automatic run_packet(input int unsigned plen, input logic [15:0] hlen,
                            input logic [31:0] pres, input bit rand_fill,
                            input logic [7:0] fill);
    build_packet(plen, hlen, pres, rand_fill, fill);
    send_packet(1'b0);
  endtask

  // result side backpressure
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(50, 200)) @(posedge clk);
      else
        repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          sent;
    int unsigned kind;
    int unsigned plen;
    logic [15:0] hlen;
    logic [31:0] pres;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= 8'h00;
    last_byte <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed packets
    run_packet(1, 16'd0, 32'h0, 1'b1, 8'h00);               // single byte
    run_packet(7, 16'd7, 32'h20, 1'b1, 8'h00);              // one byte short
    run_packet(8, 16'd0, 32'h0, 1'b0, 8'h00);               // all zero: bad length
    run_packet(8, 16'd8, 32'h0, 1'b1, 8'h00);               // no fields present
    run_packet(12, 16'd7, 32'h20, 1'b1, 8'h00);             // length below 8
    run_packet(12, 16'd13, 32'h20, 1'b1, 8'h00);            // length past packet
    run_packet(12, 16'd9, 32'h8000_0020, 1'b1, 8'h00);      // extended bitmap
    run_packet(9, 16'd9, 32'h20, 1'b0, 8'h80);              // -128 dBm
    run_packet(9, 16'd9, 32'h20, 1'b0, 8'h7F);              // +127 dBm
    run_packet(30, 16'd25, 32'h3F, 1'b0, 8'hC3);            // all fields fit
    run_packet(30, 16'd24, 32'h3F, 1'b0, 8'hC3);            // signal overruns
    run_packet(20, 16'd15, 32'h21, 1'b1, 8'h00);            // earlier field overruns
    run_packet(20, 16'd20, 32'h1F, 1'b1, 8'h00);            // signal absent
    run_packet(12, 16'd12, 32'h7FFF_FFE0, 1'b0, 8'h5A);     // high bits ignored
    run_packet(10, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 8'hFF);   // all ones
    run_packet(16, 16'd11, 32'h28, 1'b0, 8'hA5);            // channel then signal
    run_packet(8, 16'd8, 32'h20, 1'b1, 8'h00);              // state cleared after

    // random packets
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      pres = $urandom & 32'h3F;
      if ($urandom_range(0, 3) != 0)
        pres[5] = 1'b1;
      if ($urandom_range(0, 7) == 0)
        pres[30:6] = 25'($urandom);
      hlen = 16'($urandom_range(8, 32));
      plen = hlen + $urandom_range(0, 8);
      if (kind < 75) begin
      end else if (kind < 82) begin
        pres[31] = 1'b1;
      end else if (kind < 88) begin
        plen = $urandom_range(1, 7);
        hlen = 16'($urandom);
      end else if (kind < 94) begin
        if ($urandom_range(0, 1) == 0)
          hlen = 16'($urandom_range(0, 7));
        else
          hlen = 16'($urandom);
      end else begin
        plen = $urandom_range(1, 40);
        hlen = 16'($urandom);
        pres = $urandom;
      end
      run_packet(plen, hlen, pres, 1'b1, 8'h00);
      sent = sent + plen;
    end
    in_valid <= 1'b0;

    // let the checker queue the final packet's result before polling pending
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rdse_pkg.sv
rtl/core/rdse_in_reg.sv
rtl/core/rdse_parse.sv
rtl/core/rdse_out_reg.sv
rtl/core/radiotap_dbm_signal_extractor_unit.sv
rtl/core/rdse_checker.sv
sim/radiotap_dbm_signal_extractor_checker.sv
sim/radiotap_dbm_signal_extractor_unit_tb.sv
